[rtl/dgcd_pkg.sv]
// ----------------------------------------------------------------------------
// dgcd_pkg
// Shared constants and controller/datapath interface types for the
// directed graph cycle detector.
// ----------------------------------------------------------------------------
package dgcd_pkg;

  localparam int MAX_VERTICES_DEFAULT = 64;

  localparam int FIELD_W  = 6;
  localparam int COUNT_W  = 7;

  localparam logic [COUNT_W-1:0] VERTEX_COUNT_RESET = 7'd64;

  // controller -> datapath
  typedef struct packed {
    logic clear_row;    // zero one adjacency row, advance sweep
    logic clear_marks;  // zero visited/on-path marks, root index, stack pointer
    logic load;         // edge request accepted
    logic start_root;   // begin a walk at the root index
    logic root_inc;     // next root candidate
    logic cursor_inc;   // next column of the current row
    logic push;         // descend into the column vertex
    logic pop;          // drop current frame, fetch parent
    logic pop_load;     // parent frame arrives into the top registers
    logic pop_frame;    // current vertex leaves the path
    logic set_result;   // load the output register
    logic result_val;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic clear_last;
    logic root_done;
    logic root_visited;
    logic scan_end;
    logic edge_bit;
    logic target_on_path;
    logic target_visited;
    logic stack_empty;
    logic out_busy;
  } status_t;

endpackage

[rtl/directed_graph_cycle_detect.sv]
// ----------------------------------------------------------------------------
// directed_graph_cycle_detect
// Loads directed edges into an adjacency matrix and, after the last edge of
// a graph, runs an iterative depth-first search reporting any directed cycle.
//
//   channel  dir  handshake            payload
//   cfg      in   cfg_wr_en            cfg_wr_data = vertex_count
//   s        in   s_tvalid/s_tready    edges, s_tuser edge_present, s_tlast
//   m        out  m_tvalid/m_tready    has_cycle, one result per graph
//
// Edge requests load one per cycle. After the last one the search walks
// depth-first from each unvisited root candidate below the vertex count,
// scanning the matrix columns of every vertex it enters, and stops at the
// first cycle found. A clearing pass, one adjacency row a cycle, follows
// reset and every result; no edge is accepted during search or clearing.
// The result holds in an output register while the next graph loads.
// ----------------------------------------------------------------------------
module directed_graph_cycle_detect #(
  parameter int MAX_VERTICES = dgcd_pkg::MAX_VERTICES_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [6:0]  cfg_wr_data,  // vertex_count
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,      // [5:0] edge_source, [11:6] edge_target, zero pad
  input  logic        s_tuser,      // [0] edge_present
  input  logic        s_tlast,      // last_edge
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata       // [0] has_cycle, zero pad
);
  import dgcd_pkg::*;

  cmd_t    cmd;
  status_t st;
  logic    has_cycle;

  dgcd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_last  (s_tlast),
    .in_ready (s_tready),
    .st       (st),
    .cmd      (cmd)
  );

  dgcd_datapath #(
    .MAX_VERTICES (MAX_VERTICES)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .st           (st),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .edge_source  (s_tdata[5:0]),
    .edge_target  (s_tdata[11:6]),
    .edge_present (s_tuser),
    .res_valid    (m_tvalid),
    .res_taken    (m_tready),
    .has_cycle    (has_cycle)
  );

  assign m_tdata = {7'b0, has_cycle};

endmodule

[rtl/dgcd_ctrl.sv]
// ----------------------------------------------------------------------------
// dgcd_ctrl
// Sequencer: clear sweep, edge load, root loop, depth-first walk, result.
// ----------------------------------------------------------------------------
module dgcd_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              in_last,
  output logic              in_ready,
  input  dgcd_pkg::status_t st,
  output dgcd_pkg::cmd_t    cmd
);
  import dgcd_pkg::*;

  localparam logic [2:0] ST_CLEAR  = 3'd0;
  localparam logic [2:0] ST_LOAD   = 3'd1;
  localparam logic [2:0] ST_ROOT   = 3'd2;
  localparam logic [2:0] ST_WAIT   = 3'd3;
  localparam logic [2:0] ST_SCAN   = 3'd4;
  localparam logic [2:0] ST_POP    = 3'd5;
  localparam logic [2:0] ST_RESULT = 3'd6;

  logic [2:0] state, state_next;
  logic       found, found_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      found <= 1'b0;
    end else begin
      state <= state_next;
      found <= found_next;
    end
  end

  always_comb begin
    state_next = state;
    found_next = found;
    cmd        = '0;
    in_ready   = 1'b0;
    cmd.result_val = found;
    unique case (state)
      ST_CLEAR: begin
        cmd.clear_row   = 1'b1;
        cmd.clear_marks = 1'b1;
        found_next      = 1'b0;
        if (st.clear_last) state_next = ST_LOAD;
      end
      ST_LOAD: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
        if (in_valid && in_last) state_next = ST_ROOT;
      end
      ST_ROOT: begin
        if (st.root_done) begin
          state_next = ST_RESULT;
        end else if (st.root_visited) begin
          cmd.root_inc = 1'b1;
        end else begin
          cmd.start_root = 1'b1;
          state_next     = ST_WAIT;
        end
      end
      ST_WAIT: begin
        state_next = ST_SCAN;
      end
      ST_SCAN: begin
        if (st.scan_end) begin
          cmd.pop_frame = 1'b1;
          if (st.stack_empty) begin
            cmd.root_inc = 1'b1;
            state_next   = ST_ROOT;
          end else begin
            cmd.pop    = 1'b1;
            state_next = ST_POP;
          end
        end else if (!st.edge_bit) begin
          cmd.cursor_inc = 1'b1;
        end else if (st.target_on_path) begin
          found_next = 1'b1;
          state_next = ST_RESULT;
        end else if (st.target_visited) begin
          cmd.cursor_inc = 1'b1;
        end else begin
          cmd.push   = 1'b1;
          state_next = ST_WAIT;
        end
      end
      ST_POP: begin
        cmd.pop_load = 1'b1;
        state_next   = ST_WAIT;
      end
      ST_RESULT: begin
        if (!st.out_busy) begin
          cmd.set_result = 1'b1;
          state_next     = ST_CLEAR;
        end
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

endmodule

[rtl/dgcd_datapath.sv]
// ----------------------------------------------------------------------------
// dgcd_datapath
// Adjacency matrix, search marks, frame stack, cursors and output register.
// ----------------------------------------------------------------------------
module dgcd_datapath #(
  parameter int MAX_VERTICES = dgcd_pkg::MAX_VERTICES_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  dgcd_pkg::cmd_t                cmd,
  output dgcd_pkg::status_t             st,
  input  logic                          cfg_wr_en,
  input  logic [dgcd_pkg::COUNT_W-1:0]  cfg_wr_data,
  input  logic [dgcd_pkg::FIELD_W-1:0]  edge_source,
  input  logic [dgcd_pkg::FIELD_W-1:0]  edge_target,
  input  logic                          edge_present,
  output logic                          res_valid,
  input  logic                          res_taken,
  output logic                          has_cycle
);
  import dgcd_pkg::*;

  localparam int VW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int CW = $clog2(MAX_VERTICES + 1);

  logic [MAX_VERTICES-1:0] adj_mem [MAX_VERTICES];
  logic [MAX_VERTICES-1:0] adj_rd;
  logic [VW+CW-1:0]        stk_mem [MAX_VERTICES];
  logic [VW+CW-1:0]        stk_rd;

  logic [COUNT_W-1:0]      vertex_count;
  logic [CW-1:0]           n_eff;
  logic [VW-1:0]           clr_addr;
  logic [MAX_VERTICES-1:0] visited;
  logic [MAX_VERTICES-1:0] on_path;
  logic [CW-1:0]           root;
  logic [VW-1:0]           cur_u;
  logic [CW-1:0]           cur_c;
  logic [VW-1:0]           sp;
  logic [VW-1:0]           col;
  logic [VW-1:0]           src_idx;
  logic [VW-1:0]           dst_idx;
  logic                    load_wr;

  assign n_eff = (32'(vertex_count) > 32'(MAX_VERTICES)) ? CW'(MAX_VERTICES)
                                                        : CW'(vertex_count);
  assign col     = cur_c[VW-1:0];
  assign src_idx = VW'(edge_source);
  assign dst_idx = VW'(edge_target);
  assign load_wr = cmd.load && edge_present &&
                   (32'(edge_source) < 32'(MAX_VERTICES)) &&
                   (32'(edge_target) < 32'(MAX_VERTICES));

  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= VERTEX_COUNT_RESET;
    end else if (cfg_wr_en) begin
      vertex_count <= cfg_wr_data;
    end
  end

  // adjacency rows: clear sweep, single-bit edge writes, registered row read
  always_ff @(posedge clk) begin
    if (cmd.clear_row) begin
      adj_mem[clr_addr] <= '0;
    end else if (load_wr) begin
      adj_mem[src_idx][dst_idx] <= 1'b1;
    end
    adj_rd <= adj_mem[cur_u];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clear_row) begin
      clr_addr <= st.clear_last ? '0 : clr_addr + 1'b1;
    end
  end

  // suspended frames: {vertex, resume cursor}
  always_ff @(posedge clk) begin
    if (cmd.push) begin
      stk_mem[sp] <= {cur_u, CW'(cur_c + 1'b1)};
    end
    if (cmd.pop) begin
      stk_rd <= stk_mem[sp - 1'b1];
    end
  end

  // a walk that finds a cycle leaves frames behind; the clear pass drops them
  always_ff @(posedge clk) begin
    if (rst) begin
      sp <= '0;
    end else if (cmd.clear_marks) begin
      sp <= '0;
    end else if (cmd.push) begin
      sp <= sp + 1'b1;
    end else if (cmd.pop) begin
      sp <= sp - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      visited <= '0;
      on_path <= '0;
    end else if (cmd.clear_marks) begin
      visited <= '0;
      on_path <= '0;
    end else begin
      if (cmd.start_root) begin
        visited[root[VW-1:0]] <= 1'b1;
        on_path[root[VW-1:0]] <= 1'b1;
      end
      if (cmd.push) begin
        visited[col] <= 1'b1;
        on_path[col] <= 1'b1;
      end
      if (cmd.pop_frame) begin
        on_path[cur_u] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.clear_marks) begin
      root <= '0;
    end else if (cmd.root_inc) begin
      root <= root + 1'b1;
    end
    if (cmd.start_root) begin
      cur_u <= root[VW-1:0];
      cur_c <= '0;
    end else if (cmd.push) begin
      cur_u <= col;
      cur_c <= '0;
    end else if (cmd.pop_load) begin
      cur_u <= stk_rd[VW+CW-1:CW];
      cur_c <= stk_rd[CW-1:0];
    end else if (cmd.cursor_inc) begin
      cur_c <= cur_c + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (cmd.set_result) begin
      res_valid <= 1'b1;
    end else if (res_taken) begin
      res_valid <= 1'b0;
    end
    if (cmd.set_result) begin
      has_cycle <= cmd.result_val;
    end
  end

  always_comb begin
    st.clear_last     = (clr_addr == VW'(MAX_VERTICES - 1));
    st.root_done      = (root >= n_eff);
    st.root_visited   = visited[root[VW-1:0]];
    st.scan_end       = (cur_c >= n_eff);
    st.edge_bit       = adj_rd[col];
    st.target_on_path = on_path[col];
    st.target_visited = visited[col];
    st.stack_empty    = (sp == '0);
    st.out_busy       = res_valid;
  end

`ifndef SYNTHESIS
  a_path_in_visited: assert property (@(posedge clk) disable iff (rst)
    (on_path & ~visited) == '0)
    else $error("on-path vertex not marked visited");

  a_push_bound: assert property (@(posedge clk) disable iff (rst)
    cmd.push |-> (sp != VW'(MAX_VERTICES - 1)))
    else $error("frame stack overflow");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    cmd.pop |-> (sp != '0))
    else $error("pop from empty frame stack");

  a_root_fresh: assert property (@(posedge clk) disable iff (rst)
    cmd.start_root |-> (!visited[root[VW-1:0]] && (root < n_eff)))
    else $error("walk started at a visited or out-of-range root");

  a_result_shown: assert property (@(posedge clk) disable iff (rst)
    cmd.set_result |=> res_valid)
    else $error("result not presented");
`endif

endmodule
